/* hw/rtl/alpha_blend_text_overlay_top_defines.svh */
// ----------------------------------------------------------------------------
// alpha_blend_text_overlay_top_defines
// assertion macros shared by the overlay checker
// ----------------------------------------------------------------------------
`ifndef ALPHA_BLEND_TEXT_OVERLAY_TOP_DEFINES_SVH
`define ALPHA_BLEND_TEXT_OVERLAY_TOP_DEFINES_SVH

// property checked outside reset
`define ABTO_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define ABTO_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/abto_pkg.sv */
// ----------------------------------------------------------------------------
// abto_pkg
// types, constants and helpers of the alpha blend text overlay
// ----------------------------------------------------------------------------
`default_nettype none

package abto_pkg;

  localparam int STAMP_WORDS_DEF  = 8192;
  localparam int FRAME_WIDTH_DEF  = 256;
  localparam int FRAME_HEIGHT_DEF = 192;
  localparam int QUEUE_DEPTH      = 4;

  localparam logic [7:0] LUM_THRESHOLD = 8'd24;
  localparam logic [7:0] FULL_SCALE    = 8'd255;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_PIXEL = 1'b1
  } abto_kind_t;

  typedef enum logic [2:0] {
    REG_POS_X        = 3'd0,
    REG_POS_Y        = 3'd1,
    REG_SCALE        = 3'd2,
    REG_TINT_RGB     = 3'd3,
    REG_OPACITY      = 3'd4,
    REG_STAMP_WIDTH  = 3'd5,
    REG_STAMP_HEIGHT = 3'd6
  } abto_reg_t;

  typedef struct packed {
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [1:0]  scale;
    logic [23:0] tint_rgb;
    logic [7:0]  opacity;
    logic [8:0]  stamp_width;
    logic [7:0]  stamp_height;
  } abto_cfg_t;

  localparam abto_cfg_t CFG_RESET = '{
    pos_x:        8'd0,
    pos_y:        8'd0,
    scale:        2'd1,
    tint_rgb:     24'hFFFFFF,
    opacity:      8'd255,
    stamp_width:  9'd1,
    stamp_height: 8'd1
  };

  // hit: lookup inside stamp for a pixel, write allowed for a load
  typedef struct packed {
    abto_kind_t kind;
    logic       hit;
    logic [7:0] lum;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } abto_item_t;

  // exact x / 255 for x up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] sum;
    sum = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
    return sum[15:8];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/alpha_blend_text_overlay_top.sv */
// ----------------------------------------------------------------------------
// alpha_blend_text_overlay_top
// blends a luminance stamp, tinted, onto a pixel stream
// ----------------------------------------------------------------------------
// usage
//   in_*  : one request per accepted valid/ready beat; in_kind 0 loads one
//           stamp store entry, in_kind 1 is a frame pixel
//   out_* : one blended pixel per pixel request, none per load, in order
//   cfg_* : register writes; the user keeps to idle, block does not check
// timing
//   one request per cycle sustained while out_ready stays high; the
//   five-stage back pipeline (store read, opacity multiply, alpha,
//   channel mix, divide) sets the latency
// reset
//   synchronous, clears the queue, the pipeline valids and the registers;
//   the stamp store holds nothing usable until loaded
// stall
//   a low out_ready with a result offered freezes the back pipeline; the
//   4-entry queue keeps taking requests until full, then in_ready drops
// ----------------------------------------------------------------------------
`default_nettype none

module alpha_blend_text_overlay_top
  import abto_pkg::*;
#(
  parameter int STAMP_WORDS  = STAMP_WORDS_DEF,
  parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_kind,
  input  wire logic [12:0] in_store_addr,
  input  wire logic [7:0]  in_store_lum,
  input  wire logic [7:0]  in_pix_x,
  input  wire logic [7:0]  in_pix_y,
  input  wire logic [7:0]  in_red_in,
  input  wire logic [7:0]  in_green_in,
  input  wire logic [7:0]  in_blue_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_red_out,
  output logic [7:0]       out_green_out,
  output logic [7:0]       out_blue_out,
  output logic             out_covered
);

  localparam int ADDR_W = $clog2(STAMP_WORDS);
  localparam int ITEM_W = $bits(abto_item_t);
  localparam int Q_W    = ADDR_W + ITEM_W;

  abto_cfg_t         cfg_r;
  abto_item_t        f_item, q_item;
  logic [ADDR_W-1:0] f_addr, q_addr;
  logic [Q_W-1:0]    q_data;
  logic              q_full, q_valid, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      case (abto_reg_t'(cfg_index))
        REG_POS_X:        cfg_r.pos_x        <= cfg_data[7:0];
        REG_POS_Y:        cfg_r.pos_y        <= cfg_data[7:0];
        REG_SCALE:        cfg_r.scale        <= cfg_data[1:0];
        REG_TINT_RGB:     cfg_r.tint_rgb     <= cfg_data;
        REG_OPACITY:      cfg_r.opacity      <= cfg_data[7:0];
        REG_STAMP_WIDTH:  cfg_r.stamp_width  <= cfg_data[8:0];
        REG_STAMP_HEIGHT: cfg_r.stamp_height <= cfg_data[7:0];
        default:          ;
      endcase
    end
  end

  abto_front #(
    .STAMP_WORDS (STAMP_WORDS),
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT),
    .ADDR_W      (ADDR_W)
  ) u_front (
    .cfg       (cfg_r),
    .kind      (in_kind),
    .store_addr(in_store_addr),
    .store_lum (in_store_lum),
    .pix_x     (in_pix_x),
    .pix_y     (in_pix_y),
    .red_in    (in_red_in),
    .green_in  (in_green_in),
    .blue_in   (in_blue_in),
    .item      (f_item),
    .addr      (f_addr)
  );

  assign in_ready = !q_full;

  abto_queue #(
    .WIDTH(Q_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_valid),
    .push_data({f_addr, f_item}),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_valid),
    .pop_data (q_data)
  );

  assign q_item = abto_item_t'(q_data[ITEM_W-1:0]);
  assign q_addr = q_data[Q_W-1:ITEM_W];

  abto_back #(
    .STAMP_WORDS(STAMP_WORDS),
    .ADDR_W     (ADDR_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_addr     (q_addr),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_red    (out_red_out),
    .out_green  (out_green_out),
    .out_blue   (out_blue_out),
    .out_covered(out_covered)
  );

endmodule

`default_nettype wire

/* hw/rtl/abto_queue.sv */
// ----------------------------------------------------------------------------
// abto_queue
// small first-in first-out queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module abto_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/abto_front.sv */
// ----------------------------------------------------------------------------
// abto_front
// classifies requests and computes the stamp store address
// ----------------------------------------------------------------------------
`default_nettype none

module abto_front
  import abto_pkg::*;
#(
  parameter int STAMP_WORDS  = STAMP_WORDS_DEF,
  parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF,
  parameter int ADDR_W       = $clog2(STAMP_WORDS)
) (
  input  wire abto_cfg_t    cfg,
  input  wire logic         kind,
  input  wire logic [12:0]  store_addr,
  input  wire logic [7:0]   store_lum,
  input  wire logic [7:0]   pix_x,
  input  wire logic [7:0]   pix_y,
  input  wire logic [7:0]   red_in,
  input  wire logic [7:0]   green_in,
  input  wire logic [7:0]   blue_in,
  output abto_item_t        item,
  output logic [ADDR_W-1:0] addr
);

  logic        sc2;
  logic        in_frame, ge_x, ge_y, dx_in, dy_in, in_store, ld_ok, hit;
  logic [7:0]  dx, dy, ux, uy;
  logic [9:0]  rect_w;
  logic [8:0]  rect_h;
  logic [16:0] lin;
  abto_kind_t  kind_e;

  assign kind_e   = abto_kind_t'(kind);
  assign sc2      = cfg.scale[1];
  assign in_frame = (32'(pix_x) < FRAME_WIDTH) && (32'(pix_y) < FRAME_HEIGHT);
  assign ge_x     = pix_x >= cfg.pos_x;
  assign ge_y     = pix_y >= cfg.pos_y;
  assign dx       = pix_x - cfg.pos_x;
  assign dy       = pix_y - cfg.pos_y;
  assign rect_w   = sc2 ? {cfg.stamp_width, 1'b0} : {1'b0, cfg.stamp_width};
  assign rect_h   = sc2 ? {cfg.stamp_height, 1'b0} : {1'b0, cfg.stamp_height};
  assign dx_in    = {2'b0, dx} < rect_w;
  assign dy_in    = {1'b0, dy} < rect_h;
  assign ux       = sc2 ? {1'b0, dx[7:1]} : dx;
  assign uy       = sc2 ? {1'b0, dy[7:1]} : dy;
  assign lin      = ({9'b0, uy} * {8'b0, cfg.stamp_width}) + {9'b0, ux};
  assign in_store = 32'(lin) < STAMP_WORDS;
  assign ld_ok    = 32'(store_addr) < STAMP_WORDS;
  assign hit      = in_frame && ge_x && ge_y && dx_in && dy_in && in_store;

  always_comb begin
    item.kind  = kind_e;
    item.hit   = (kind_e == KIND_PIXEL) ? hit : ld_ok;
    item.lum   = store_lum;
    item.red   = red_in;
    item.green = green_in;
    item.blue  = blue_in;
    addr       = (kind_e == KIND_PIXEL) ? ADDR_W'(lin) : ADDR_W'(store_addr);
  end

endmodule

`default_nettype wire

/* hw/rtl/abto_back.sv */
// ----------------------------------------------------------------------------
// abto_back
// stamp store access and blend pipeline with output register
// ----------------------------------------------------------------------------
`default_nettype none

module abto_back
  import abto_pkg::*;
#(
  parameter int STAMP_WORDS = STAMP_WORDS_DEF,
  parameter int ADDR_W      = $clog2(STAMP_WORDS)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire abto_cfg_t         cfg,
  input  wire logic              q_valid,
  input  wire abto_item_t        q_item,
  input  wire logic [ADDR_W-1:0] q_addr,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_red,
  output logic [7:0]             out_green,
  output logic [7:0]             out_blue,
  output logic                   out_covered
);

  logic [7:0] mem [STAMP_WORDS];

  logic        en;
  logic        s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, s5_valid_r;
  logic        s1_hit_r, s2_hit_r, s3_hit_r, s4_hit_r, s5_hit_r;
  logic [7:0]  rd_lum_r;
  logic [15:0] s2_prod_r;
  logic [7:0]  s3_a_r;
  logic [23:0] s1_rgb_r, s2_rgb_r, s3_rgb_r, s4_rgb_r;
  logic [15:0] s4_mix_r [3];
  logic [15:0] mix_nxt [3];
  logic [7:0]  s5_red_r, s5_green_r, s5_blue_r;
  logic [7:0]  inv_a;

  assign en    = !s5_valid_r || out_ready;
  assign q_pop = en && q_valid;
  assign inv_a = FULL_SCALE - s3_a_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mix_nxt[i] = ({8'b0, s3_rgb_r[8*i +: 8]} * {8'b0, inv_a})
                 + ({8'b0, cfg.tint_rgb[8*i +: 8]} * {8'b0, s3_a_r});
    end
  end

  // stamp store
  always_ff @(posedge clk) begin
    if (q_pop && q_item.kind == KIND_LOAD && q_item.hit) begin
      mem[q_addr] <= q_item.lum;
    end
    if (en) begin
      rd_lum_r <= mem[q_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= q_pop && q_item.kind == KIND_PIXEL;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
      s5_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_hit_r   <= q_item.hit;
      s1_rgb_r   <= {q_item.red, q_item.green, q_item.blue};
      s2_hit_r   <= s1_hit_r && (rd_lum_r >= LUM_THRESHOLD);
      s2_prod_r  <= {8'b0, rd_lum_r} * {8'b0, cfg.opacity};
      s2_rgb_r   <= s1_rgb_r;
      s3_hit_r   <= s2_hit_r;
      s3_a_r     <= div255(s2_prod_r);
      s3_rgb_r   <= s2_rgb_r;
      s4_hit_r   <= s3_hit_r;
      s4_mix_r   <= mix_nxt;
      s4_rgb_r   <= s3_rgb_r;
      s5_hit_r   <= s4_hit_r;
      s5_red_r   <= s4_hit_r ? div255(s4_mix_r[2]) : s4_rgb_r[23:16];
      s5_green_r <= s4_hit_r ? div255(s4_mix_r[1]) : s4_rgb_r[15:8];
      s5_blue_r  <= s4_hit_r ? div255(s4_mix_r[0]) : s4_rgb_r[7:0];
    end
  end

  assign out_valid   = s5_valid_r;
  assign out_red     = s5_red_r;
  assign out_green   = s5_green_r;
  assign out_blue    = s5_blue_r;
  assign out_covered = s5_hit_r;

endmodule

`default_nettype wire

/* hw/rtl/abto_checker.sv */
// ----------------------------------------------------------------------------
// abto_checker
// port-level checks of the overlay, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "alpha_blend_text_overlay_top_defines.svh"

module abto_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready
);

  // stalled result stays offered
  `ABTO_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  // queue only fills while the output is stalled
  `ABTO_ASSERT(a_full_needs_stall, clk, rst_n, !in_ready |-> $past(out_valid && !out_ready), "in_ready low without output stall")

  // reset empties the block
  `ABTO_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n ##1 1'b1 |-> !out_valid && in_ready, "block not clear after reset")

endmodule

bind alpha_blend_text_overlay_top abto_checker u_abto_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready)
);

`default_nettype wire
